// ===== design/label_border_overlay_top_defines.svh =====
// Assertion macros for the label border overlay block.
`ifndef LABEL_BORDER_OVERLAY_TOP_DEFINES_SVH
`define LABEL_BORDER_OVERLAY_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBO_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBO_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lbo_pkg.sv =====
// Shared types and constants for the label border overlay block.
`timescale 1ns / 1ps
package lbo_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 4;
  localparam int LABEL_BITS_DEF = 16;

  localparam int LABEL_W    = 16;
  localparam int PIX_W      = 8;
  localparam int FRAME_W_W  = 11;
  localparam int FRAME_H_W  = 16;
  localparam int RADIUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_LUMA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_CB    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_CR    = 3'd5;

  localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST       = 3'd1;
  localparam logic [PIX_W-1:0]     BORDER_LUMA_RST  = 8'd0;
  localparam logic [PIX_W-1:0]     BORDER_CB_RST    = 8'd128;
  localparam logic [PIX_W-1:0]     BORDER_CR_RST    = 8'd128;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [LABEL_W-1:0] label;
    logic [PIX_W-1:0]   luma;
    logic [PIX_W-1:0]   chroma_b;
    logic [PIX_W-1:0]   chroma_r;
  } lbo_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_luma;
    logic [PIX_W-1:0] out_cb;
    logic [PIX_W-1:0] out_cr;
    logic             painted;
    logic             frame_end;
  } lbo_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } lbo_cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic wr_px;
    logic scan_init;
    logic scan_step;
    logic load_out;
  } lbo_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_done;
    logic lag_met;
    logic scan_last;
    logic out_free;
  } lbo_stat_t;

endpackage

// ===== design/lbo_if.sv =====
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
interface lbo_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/lbo_ctrl.sv =====
// Controller state machine: sequences pixel writes, neighborhood scan and result load.
`timescale 1ns / 1ps
module lbo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  input  lbo_pkg::lbo_stat_t st,
  output lbo_pkg::lbo_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OWN  = 5'b00010,
    S_SCAN = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (st.in_done) begin
            // frame complete: any beat drains one pending result
            state_nxt = S_OWN;
          end else if (in_mode == lbo_pkg::MODE_PIXEL) begin
            cmd.wr_px = 1'b1;
            if (st.lag_met) state_nxt = S_OWN;
          end
        end
      end
      S_OWN: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== design/lbo_datapath.sv =====
// Datapath: config registers, line stores, raster counters, disk scan and output register.
`timescale 1ns / 1ps
module lbo_datapath #(
  parameter int MAX_WIDTH  = lbo_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = lbo_pkg::MAX_RADIUS_DEF,
  parameter int LABEL_BITS = lbo_pkg::LABEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lbo_pkg::lbo_in_t   in_data,
  input  logic               cfg_valid,
  input  lbo_pkg::lbo_cfg_t  cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output lbo_pkg::lbo_out_t  out_data,
  input  lbo_pkg::lbo_cmd_t  cmd,
  output lbo_pkg::lbo_stat_t st
);

  localparam int LDEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int CDEPTH = (MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int CAW    = $clog2(CDEPTH);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int LAGW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int HW     = lbo_pkg::FRAME_H_W;
  localparam int PW     = lbo_pkg::PIX_W;
  localparam int SQW    = 2 * RW + 4;

  // configuration registers
  logic [lbo_pkg::FRAME_W_W-1:0] fw_r;
  logic [HW-1:0]                 fh_r;
  logic [lbo_pkg::RADIUS_W-1:0]  rad_r;
  logic [PW-1:0]                 bl_r, bcb_r, bcr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= lbo_pkg::FRAME_WIDTH_RST;
      fh_r  <= lbo_pkg::FRAME_HEIGHT_RST;
      rad_r <= lbo_pkg::RADIUS_RST;
      bl_r  <= lbo_pkg::BORDER_LUMA_RST;
      bcb_r <= lbo_pkg::BORDER_CB_RST;
      bcr_r <= lbo_pkg::BORDER_CR_RST;
    end else if (cfg_valid) begin
      case (cfg_data.index)
        lbo_pkg::REG_FRAME_WIDTH:  fw_r  <= cfg_data.value[lbo_pkg::FRAME_W_W-1:0];
        lbo_pkg::REG_FRAME_HEIGHT: fh_r  <= cfg_data.value[HW-1:0];
        lbo_pkg::REG_RADIUS:       rad_r <= cfg_data.value[lbo_pkg::RADIUS_W-1:0];
        lbo_pkg::REG_BORDER_LUMA:  bl_r  <= cfg_data.value[PW-1:0];
        lbo_pkg::REG_BORDER_CB:    bcb_r <= cfg_data.value[PW-1:0];
        lbo_pkg::REG_BORDER_CR:    bcr_r <= cfg_data.value[PW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [WW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic [RW-1:0]      eff_r;
  logic [RW+WW-1:0]   rw_prod;
  logic [LAGW-1:0]    lag;

  always_comb begin
    if (fw_r == '0)                       eff_w = WW'(1);
    else if (32'(fw_r) > 32'(MAX_WIDTH))  eff_w = WW'(MAX_WIDTH);
    else                                  eff_w = WW'(fw_r);
    eff_h = (fh_r == '0) ? HW'(1) : fh_r;
    eff_r = (32'(rad_r) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(rad_r);
  end

  assign rw_prod = (RW+WW)'(eff_r) * (RW+WW)'(eff_w);
  assign lag     = LAGW'(rw_prod) + LAGW'(eff_r);

  // raster position counters
  logic [XW-1:0]   in_col_r, out_col_r;
  logic [HW-1:0]   in_row_r, out_row_r;
  logic [LAW-1:0]  in_laddr_r, out_laddr_r;
  logic [CAW-1:0]  in_caddr_r, out_caddr_r;
  logic [LAGW-1:0] cnt_r;
  logic            in_done_r;
  logic            in_col_wrap, in_last, out_col_wrap, out_last;

  assign in_col_wrap  = (WW'(in_col_r) == eff_w - WW'(1));
  assign in_last      = in_col_wrap && (in_row_r == eff_h - HW'(1));
  assign out_col_wrap = (WW'(out_col_r) == eff_w - WW'(1));
  assign out_last     = out_col_wrap && (out_row_r == eff_h - HW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_laddr_r  <= '0;
      in_caddr_r  <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_laddr_r <= '0;
      out_caddr_r <= '0;
      cnt_r       <= '0;
      in_done_r   <= 1'b0;
    end else if (cmd.load_out && out_last) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_laddr_r  <= '0;
      in_caddr_r  <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_laddr_r <= '0;
      out_caddr_r <= '0;
      cnt_r       <= '0;
      in_done_r   <= 1'b0;
    end else begin
      if (cmd.wr_px) begin
        in_col_r   <= in_col_wrap ? '0 : in_col_r + XW'(1);
        if (in_col_wrap) in_row_r <= in_row_r + HW'(1);
        in_laddr_r <= (in_laddr_r == LAW'(LDEPTH - 1)) ? '0 : in_laddr_r + LAW'(1);
        in_caddr_r <= (in_caddr_r == CAW'(CDEPTH - 1)) ? '0 : in_caddr_r + CAW'(1);
        if (in_last) in_done_r <= 1'b1;
        if (!(cnt_r >= lag)) cnt_r <= cnt_r + LAGW'(1);
      end
      if (cmd.load_out) begin
        out_col_r   <= out_col_wrap ? '0 : out_col_r + XW'(1);
        if (out_col_wrap) out_row_r <= out_row_r + HW'(1);
        out_laddr_r <= (out_laddr_r == LAW'(LDEPTH - 1)) ? '0 : out_laddr_r + LAW'(1);
        out_caddr_r <= (out_caddr_r == CAW'(CDEPTH - 1)) ? '0 : out_caddr_r + CAW'(1);
        if (in_done_r) cnt_r <= cnt_r - LAGW'(1);
      end
    end
  end

  // disk scan counters
  logic signed [RW:0] dx_r, dy_r, r_s, neg_r;
  logic [LAW-1:0]     row_addr_r, row_base, row_next, nb_addr, rd_addr;
  logic [LAW:0]       rw_a, row_sum;
  logic [LAW+1:0]     nb_sum;
  logic [SQW-1:0]     sq_sum, r_sq;
  logic signed [HW+1:0] y_pos;
  logic signed [XW+2:0] x_pos;
  logic               disk_ok, frame_ok, scan_last;

  assign r_s   = $signed({1'b0, eff_r});
  assign neg_r = -r_s;
  assign rw_a  = (LAW+1)'(rw_prod);

  always_comb begin
    if ((LAW+1)'(out_laddr_r) >= rw_a)
      row_base = LAW'((LAW+1)'(out_laddr_r) - rw_a);
    else
      row_base = LAW'((LAW+1)'(out_laddr_r) + (LAW+1)'(LDEPTH) - rw_a);
    row_sum  = (LAW+1)'(row_addr_r) + (LAW+1)'(eff_w);
    row_next = (row_sum >= (LAW+1)'(LDEPTH)) ? LAW'(row_sum - (LAW+1)'(LDEPTH))
                                             : LAW'(row_sum);
    nb_sum = (LAW+2)'(row_addr_r) + (LAW+2)'(LDEPTH) + (LAW+2)'(dx_r);
    if (nb_sum >= (LAW+2)'(2 * LDEPTH))  nb_addr = LAW'(nb_sum - (LAW+2)'(2 * LDEPTH));
    else if (nb_sum >= (LAW+2)'(LDEPTH)) nb_addr = LAW'(nb_sum - (LAW+2)'(LDEPTH));
    else                                 nb_addr = LAW'(nb_sum);
  end

  always_comb begin
    // offsets widened before squaring so r*r does not wrap
    sq_sum   = SQW'(SQW'(dx_r) * SQW'(dx_r)) + SQW'(SQW'(dy_r) * SQW'(dy_r));
    r_sq     = SQW'(eff_r) * SQW'(eff_r);
    disk_ok  = (sq_sum <= r_sq);
    y_pos    = $signed({2'b00, out_row_r}) + (HW+2)'(dy_r);
    x_pos    = $signed({3'b000, out_col_r}) + (XW+3)'(dx_r);
    frame_ok = (y_pos >= 0) && (y_pos < $signed({2'b00, eff_h})) &&
               (x_pos >= 0) && (x_pos < $signed((XW+3)'(eff_w)));
    scan_last = (dx_r == r_s) && (dy_r == r_s);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      dx_r       <= neg_r;
      dy_r       <= neg_r;
      row_addr_r <= row_base;
    end else if (cmd.scan_step) begin
      if (dx_r == r_s) begin
        dx_r       <= neg_r;
        dy_r       <= dy_r + (RW+1)'(1);
        row_addr_r <= row_next;
      end else begin
        dx_r <= dx_r + (RW+1)'(1);
      end
    end
  end

  // line stores
  logic [LABEL_BITS-1:0] label_mem [LDEPTH];
  logic [23:0]           color_mem [CDEPTH];
  logic [LABEL_BITS-1:0] label_q, own_r;
  logic [23:0]           color_q, col_r;
  logic [31:0]           lbl_ext;

  assign lbl_ext = 32'(in_data.label);
  assign rd_addr = cmd.scan_init ? out_laddr_r : nb_addr;

  always_ff @(posedge clk) begin
    if (cmd.wr_px) begin
      label_mem[in_laddr_r] <= lbl_ext[LABEL_BITS-1:0];
      color_mem[in_caddr_r] <= {in_data.chroma_r, in_data.chroma_b, in_data.luma};
    end
    label_q <= label_mem[rd_addr];
    color_q <= color_mem[out_caddr_r];
  end

  // compare pipeline: read issued one cycle, checked the next
  logic own_cap_r, chk_pend_r, border_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_cap_r  <= 1'b0;
      chk_pend_r <= 1'b0;
      border_r   <= 1'b0;
    end else begin
      own_cap_r  <= cmd.scan_init;
      chk_pend_r <= cmd.scan_step && disk_ok && frame_ok;
      if (cmd.scan_init) border_r <= 1'b0;
      else if (chk_pend_r && (label_q != own_r)) border_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (own_cap_r) begin
      own_r <= label_q;
      col_r <= color_q;
    end
  end

  // output register
  logic              out_valid_r;
  lbo_pkg::lbo_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.out_luma  <= border_r ? bl_r  : col_r[7:0];
      out_r.out_cb    <= border_r ? bcb_r : col_r[15:8];
      out_r.out_cr    <= border_r ? bcr_r : col_r[23:16];
      out_r.painted   <= border_r;
      out_r.frame_end <= out_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign st.in_done   = in_done_r;
  assign st.lag_met   = (cnt_r >= lag);
  assign st.scan_last = scan_last;
  assign st.out_free  = !out_valid_r || out_ready;

endmodule

// ===== design/label_border_overlay_top.sv =====
// Top level of the label border overlay block.
`timescale 1ns / 1ps
// Label border overlay: takes a raster stream of Y/Cb/Cr pixels with region
// labels and paints every pixel that has a differently labelled in-frame
// neighbor inside a disk of the configured radius in the border color. A
// result leaves radius rows plus radius columns behind the input; once the
// last pixel of a frame is in, each further beat (flush or pixel, pixel data
// is dropped) drains one result. A flush beat mid-frame does nothing. Each
// result takes 2*radius+1 squared neighbor reads from the label line store,
// one per cycle on its single read port, then waits in the output state
// until the result register is free. The result register lets the next
// beat in while a result waits.
// Config writes are taken any time but belong between frames.
module label_border_overlay_top #(
  parameter int MAX_WIDTH  = lbo_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = lbo_pkg::MAX_RADIUS_DEF,
  parameter int LABEL_BITS = lbo_pkg::LABEL_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  lbo_if.sink   in_ch,
  lbo_if.source out_ch,
  lbo_if.sink   cfg_ch
);

`include "label_border_overlay_top_defines.svh"

  lbo_pkg::lbo_cmd_t  cmd;
  lbo_pkg::lbo_stat_t st;
  logic               in_accept;

  // config writes are always accepted
  assign cfg_ch.ready = 1'b1;
  assign in_accept    = in_ch.valid && in_ch.ready;

  lbo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.data.mode),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lbo_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .LABEL_BITS (LABEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .cmd       (cmd),
    .st        (st)
  );

  // a beat after frame completion always starts a drain scan
  `LBO_ASSERT_NEXT(a_drain_scans, in_accept && st.in_done, !in_ch.ready, "drain beat did not scan")
  // result load only into a free output register
  `LBO_ASSERT_NOW(a_load_free, cmd.load_out, st.out_free, "result overwrote pending beat")
  // a loaded result shows up on the output
  `LBO_ASSERT_NEXT(a_load_valid, cmd.load_out, out_ch.valid, "loaded result not presented")

endmodule

// ===== bench/lbo_checker.sv =====
// Scoreboard for the label border overlay: predicts each result beat and compares.
`timescale 1ns / 1ps
module lbo_checker
  import lbo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  lbo_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  lbo_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  lbo_cfg_t cfg_data,
  output int       pending,
  output int       errors
);

  localparam int MAXW    = MAX_WIDTH_DEF;
  localparam int MAXR    = MAX_RADIUS_DEF;
  localparam int LBL_DEP = (2 * MAXR + 1) * MAXW;
  localparam int CLR_DEP = (MAXR + 1) * MAXW;

  logic [FRAME_W_W-1:0] width_q;
  logic [FRAME_H_W-1:0] height_q;
  logic [RADIUS_W-1:0]  radius_q;
  logic [PIX_W-1:0]     paint_y, paint_cb, paint_cr;

  logic [LABEL_W-1:0] label_store [LBL_DEP];
  logic [23:0]        color_store [CLR_DEP];
  int unsigned        px_col, px_row, res_col, res_row;

  lbo_out_t expected_px [$];

  assign pending = expected_px.size();

  initial begin
    errors = 0;
    for (int i = 0; i < LBL_DEP; i++) label_store[i] = '0;
    for (int i = 0; i < CLR_DEP; i++) color_store[i] = '0;
  end

  function automatic int unsigned cur_w();
    int unsigned w;
    w = width_q;
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned cur_h();
    return (height_q == 0) ? 1 : height_q;
  endfunction

  function automatic int unsigned cur_r();
    return (radius_q > MAXR) ? MAXR : radius_q;
  endfunction

  // Produce the result for the next output position and advance it.
  function automatic void paint_next();
    int unsigned w, h, r, total, olin;
    int          y, x, ri;
    logic [LABEL_W-1:0] own;
    logic [23:0]        clr;
    logic               hit;
    lbo_out_t           res;
    w = cur_w(); h = cur_h(); r = cur_r();
    ri = r;
    total = w * h;
    olin = res_row * w + res_col;
    own = label_store[olin % LBL_DEP];
    clr = color_store[olin % CLR_DEP];
    hit = 1'b0;
    for (int dy = -ri; dy <= ri; dy++) begin
      for (int dx = -ri; dx <= ri; dx++) begin
        y = int'(res_row) + dy;
        x = int'(res_col) + dx;
        if (dx * dx + dy * dy <= ri * ri && y >= 0 && y < int'(h) && x >= 0 && x < int'(w))
          if (label_store[(y * w + x) % LBL_DEP] != own) hit = 1'b1;
      end
    end
    if (hit) begin
      res.out_luma = paint_y; res.out_cb = paint_cb; res.out_cr = paint_cr;
    end else begin
      res.out_luma = clr[7:0]; res.out_cb = clr[15:8]; res.out_cr = clr[23:16];
    end
    res.painted = hit;
    if (olin + 1 >= total) begin
      res.frame_end = 1'b1;
      px_col = 0; px_row = 0; res_col = 0; res_row = 0;
    end else begin
      res.frame_end = 1'b0;
      res_col++;
      if (res_col >= w) begin
        res_col = 0;
        res_row = (res_row + 1) & 16'hFFFF;
      end
    end
    expected_px.push_back(res);
  endfunction

  function automatic void take_beat(lbo_in_t b);
    int unsigned w, h, r, total, ilin, olin;
    w = cur_w(); h = cur_h(); r = cur_r();
    total = w * h;
    ilin = px_row * w + px_col;
    olin = res_row * w + res_col;
    if (ilin >= total) begin
      paint_next();   // frame complete: any beat drains one result
    end else if (b.mode == MODE_PIXEL) begin
      label_store[ilin % LBL_DEP] = b.label;
      color_store[ilin % CLR_DEP] = {b.chroma_r, b.chroma_b, b.luma};
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        px_row = (px_row + 1) & 16'hFFFF;
      end
      if (olin + r * w + r <= ilin) paint_next();
    end
  endfunction

  always @(posedge clk) begin
    lbo_out_t exp_px;
    if (!rst_n) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      radius_q <= RADIUS_RST;
      paint_y  <= BORDER_LUMA_RST;
      paint_cb <= BORDER_CB_RST;
      paint_cr <= BORDER_CR_RST;
      px_col = 0; px_row = 0; res_col = 0; res_row = 0;
      expected_px.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          $error("unexpected result beat: luma %0d cb %0d cr %0d",
                 out_data.out_luma, out_data.out_cb, out_data.out_cr);
          errors++;
        end else begin
          exp_px = expected_px.pop_front();
          if (out_data.out_luma !== exp_px.out_luma) begin
            $error("out_luma expected %0d got %0d", exp_px.out_luma, out_data.out_luma);
            errors++;
          end
          if (out_data.out_cb !== exp_px.out_cb) begin
            $error("out_cb expected %0d got %0d", exp_px.out_cb, out_data.out_cb);
            errors++;
          end
          if (out_data.out_cr !== exp_px.out_cr) begin
            $error("out_cr expected %0d got %0d", exp_px.out_cr, out_data.out_cr);
            errors++;
          end
          if (out_data.painted !== exp_px.painted) begin
            $error("painted expected %0d got %0d", exp_px.painted, out_data.painted);
            errors++;
          end
          if (out_data.frame_end !== exp_px.frame_end) begin
            $error("frame_end expected %0d got %0d", exp_px.frame_end, out_data.frame_end);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) take_beat(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_FRAME_WIDTH:  width_q  <= cfg_data.value[FRAME_W_W-1:0];
          REG_FRAME_HEIGHT: height_q <= cfg_data.value[FRAME_H_W-1:0];
          REG_RADIUS:       radius_q <= cfg_data.value[RADIUS_W-1:0];
          REG_BORDER_LUMA:  paint_y  <= cfg_data.value[PIX_W-1:0];
          REG_BORDER_CB:    paint_cb <= cfg_data.value[PIX_W-1:0];
          REG_BORDER_CR:    paint_cr <= cfg_data.value[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the label border overlay: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
  import lbo_pkg::*;

  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  DRAIN_WAIT  = 120;    // beyond the slowest emitting beat, at the largest radius
  localparam int  HOLD_LEN    = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  lbo_if #(.payload_t(lbo_in_t))  in_if  ();
  lbo_if #(.payload_t(lbo_out_t)) out_if ();
  lbo_if #(.payload_t(lbo_cfg_t)) cfg_if ();

  label_border_overlay_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  int pending;
  int errors;

  lbo_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_data   (in_if.data),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_data  (cfg_if.data),
    .pending   (pending),
    .errors    (errors)
  );

  // Flow control knobs shared by the stimulus and the result sink.
  bit quiet;      // no idling on either side
  bit hold_req;   // ask the sink for one long hold-off

  int unsigned cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink: random stalls, mostly short, a few long; one long hold on request.
  initial begin
    int stall_left;
    int pick;
    out_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_LEN;
      end else if (stall_left == 0 && !quiet) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)       stall_left = $urandom_range(10, 50);
        else if (pick < 22) stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic int gap_len();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One input beat; valid is held across back-to-back beats.
  task automatic send_beat(lbo_in_t b);
    int gap;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    #1;
    while (!in_if.ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    #1;
    while (!cfg_if.ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Block is idle: nothing expected, and any non-emitting beat has finished too.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic lbo_in_t rand_beat(logic md);
    lbo_in_t b;
    b.mode     = md;
    b.label    = 16'($urandom);
    b.luma     = 8'($urandom);
    b.chroma_b = 8'($urandom);
    b.chroma_r = 8'($urandom);
    return b;
  endfunction

  // One whole frame: config, pixels (with mid-frame flush noise), then the tail drain.
  // style 0: blocky regions, 1: one flat label, 2: fully random labels.
  task automatic run_frame(int w, int h, int r, int style, bit long_hold);
    int weff, reff, npx, lag, tail, bw, bh;
    logic [LABEL_W-1:0] base;
    lbo_in_t b;
    wait_idle();
    write_reg(REG_FRAME_WIDTH,  CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_RADIUS,       CFG_DATA_W'(r));
    write_reg(REG_BORDER_LUMA,  CFG_DATA_W'($urandom_range(0, 255)));
    write_reg(REG_BORDER_CB,    CFG_DATA_W'($urandom_range(0, 255)));
    write_reg(REG_BORDER_CR,    CFG_DATA_W'($urandom_range(0, 255)));
    weff = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    reff = (r > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : r;
    npx  = weff * h;
    lag  = reff * weff + reff;
    tail = (npx < lag) ? npx : lag;
    bw   = $urandom_range(1, 4);
    bh   = $urandom_range(1, 4);
    base = ($urandom_range(0, 1) == 1) ? 16'hFFFE : 16'($urandom_range(0, 3));
    if (long_hold) hold_req = 1'b1;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < weff; x++) begin
        if (!quiet && $urandom_range(0, 99) < 5) send_beat(rand_beat(MODE_FLUSH));
        b = rand_beat(MODE_PIXEL);
        if (style == 1) b.label = base;
        else if (style == 0 && $urandom_range(0, 99) >= 5)
          b.label = base + LABEL_W'(((x / bw) + (y / bh)) % 2);
        send_beat(b);
      end
    end
    // Tail: pixel beats here carry dropped data and drain like flushes.
    for (int i = 0; i < tail; i++)
      send_beat(rand_beat(($urandom_range(0, 3) == 0) ? MODE_PIXEL : MODE_FLUSH));
    if ($urandom_range(0, 3) == 0) send_beat(rand_beat(MODE_FLUSH));  // nothing pending
  endtask

  initial begin
    int w, h, r;
    lbo_in_t b;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: 4x3, radius 1, extreme labels and colors.
    wait_idle();
    write_reg(REG_FRAME_WIDTH,  CFG_DATA_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    write_reg(REG_RADIUS,       CFG_DATA_W'(1));
    write_reg(REG_BORDER_LUMA,  CFG_DATA_W'(255));
    write_reg(REG_BORDER_CB,    CFG_DATA_W'(0));
    write_reg(REG_BORDER_CR,    CFG_DATA_W'(255));
    send_beat(rand_beat(MODE_FLUSH));            // flush before the frame is full
    for (int i = 0; i < 12; i++) begin
      b.mode     = MODE_PIXEL;
      b.label    = (i % 4 < 2) ? 16'h0000 : 16'hFFFF;
      b.luma     = (i % 2 == 0) ? 8'h00 : 8'hFF;
      b.chroma_b = (i % 3 == 0) ? 8'hFF : 8'h00;
      b.chroma_r = (i % 2 == 0) ? 8'hFF : 8'h00;
      send_beat(b);
    end
    send_beat(rand_beat(MODE_PIXEL));            // pixel during the tail drains
    for (int i = 0; i < 4; i++) send_beat(rand_beat(MODE_FLUSH));
    send_beat(rand_beat(MODE_FLUSH));            // nothing pending
    run_frame(1, 1, 4, 2, 1'b0);                 // single-pixel frame
    run_frame(6, 4, 4, 1, 1'b0);                 // flat label: no border

    // Sink holds off while the sender keeps offering.
    run_frame(8, 6, 1, 0, 1'b1);

    // Random frames, mostly small.
    for (int f = 0; f < 10; f++) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 6);
      r = $urandom_range(1, 4);
      run_frame(w, h, r, ($urandom_range(0, 9) == 0) ? 2 : (($urandom_range(0, 9) == 0) ? 1 : 0),
                1'b0);
    end

    run_frame(5, 4, 3, 0, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
